FILE: rtl/core/rpc_pkg.sv
// shared types and constants for the record pack compactor
// no dependencies; imported by every rtl/core module
package rpc_pkg;

  localparam int MAX_FIELDS_DEF = 64;
  localparam int QUEUE_DEPTH    = 8;
  localparam int MAX_PUSH       = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_PREFIX = 2'd1;
  localparam logic [1:0] STATUS_EARLY  = 2'd2;

  localparam logic [1:0] PRE_NONE = 2'd0;
  localparam logic [1:0] PRE_ONE  = 2'd1;
  localparam logic [1:0] PRE_TWO  = 2'd2;

  // one descriptor table entry
  typedef struct packed {
    logic        fixed_binary;
    logic [1:0]  prefix_size;
    logic [15:0] field_length;
  } rpc_entry_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        record_done;
    logic [15:0] packed_length;
    logic [1:0]  status;
  } rpc_result_t;

endpackage

FILE: rtl/core/record_pack_compactor.sv
// record pack compactor: top level, joins descriptor table, packing step and result queue
// depends on rpc_pkg, rpc_table, rpc_step, rpc_queue
// a byte item's results enter the result queue the cycle after it is accepted
// throughput: one item per cycle unless in_stall; one result leaves per cycle unless out_stall,
//   and a field's prefix can add up to two extra results, absorbed by an eight-entry result queue
// reset: synchronous rst clears field_count, record state and queue; table holds old contents
module record_pack_compactor #(
  parameter int MAX_FIELDS = rpc_pkg::MAX_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: field_count register
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [5:0]  field_slot,
  input  logic [15:0] field_length,
  input  logic [1:0]  prefix_size,
  input  logic        fixed_binary,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        record_done,
  output logic [15:0] packed_length,
  output logic [1:0]  status
);
  import rpc_pkg::*;

  // table index width and field counter width (counter must reach MAX_FIELDS)
  localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int CF_W  = $clog2(MAX_FIELDS + 1);

  logic [6:0]      field_count;
  logic [CF_W-1:0] count_eff;
  logic            in_accept;
  logic            byte_accept;
  logic            load_we;
  rpc_entry_t      load_entry;
  rpc_entry_t      cur_entry;
  logic [CF_W-1:0] field_next;
  logic [1:0]      step_push_n;
  logic [1:0]      push_n;
  rpc_result_t     step_res [MAX_PUSH];
  rpc_result_t     head;
  logic            space_low;

  // configuration register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      field_count <= 7'd0;
    end else if (cfg_we) begin
      field_count <= cfg_wdata;
    end
  end

  // a count above the table size acts as the table size
  assign count_eff = ({25'b0, field_count} > MAX_FIELDS) ? CF_W'(MAX_FIELDS)
                                                         : CF_W'(field_count);

  // stall depends only on queue fill, never on out_stall
  assign in_stall    = space_low;
  assign in_accept   = in_valid && !in_stall;
  assign byte_accept = in_accept && (req_type == REQ_BYTE);

  // descriptor loads; slots past the table are dropped
  assign load_we = in_accept && (req_type == REQ_LOAD) && ({26'b0, field_slot} < MAX_FIELDS);
  assign load_entry.fixed_binary = fixed_binary;
  assign load_entry.prefix_size  = prefix_size;
  assign load_entry.field_length = field_length;

  // table prefetches the entry of the field the next byte belongs to
  rpc_table #(
    .MAX_FIELDS (MAX_FIELDS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(field_slot)),
    .wdata (load_entry),
    .raddr (field_next[IDX_W-1:0]),
    .rdata (cur_entry)
  );

  // packing logic: up to three results per byte item
  rpc_step #(
    .CF_W       (CF_W)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (byte_accept),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .count_eff   (count_eff),
    .entry       (cur_entry),
    .field_next  (field_next),
    .push_n      (step_push_n),
    .res         (step_res)
  );

  // only byte items produce results
  assign push_n = byte_accept ? step_push_n : 2'd0;

  // result queue parts input and output handshakes
  rpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_res  (step_res),
    .space_low (space_low),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte      = head.out_byte;
  assign byte_valid    = head.byte_valid;
  assign record_done   = head.record_done;
  assign packed_length = head.packed_length;
  assign status        = head.status;

  // loads never produce results
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && req_type == REQ_LOAD) |-> (push_n == 2'd0))
    else $error("load item produced results");

endmodule

FILE: rtl/core/rpc_table.sv
// descriptor table memory, one write port, one registered read port
// depends on rpc_pkg
module rpc_table #(
  parameter int MAX_FIELDS = rpc_pkg::MAX_FIELDS_DEF,
  parameter int IDX_W      = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  rpc_pkg::rpc_entry_t wdata,
  input  logic [IDX_W-1:0]    raddr,
  output rpc_pkg::rpc_entry_t rdata
);
  import rpc_pkg::*;

  rpc_entry_t mem [MAX_FIELDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-through so a load to the slot being fetched is seen at once
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rpc_step.sv
// per-item packing logic and record state registers
// depends on rpc_pkg; table entry comes from rpc_table
module rpc_step #(
  parameter int CF_W       = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [CF_W-1:0]     count_eff,
  input  rpc_pkg::rpc_entry_t entry,
  output logic [CF_W-1:0]     field_next,
  output logic [1:0]          push_n,
  output rpc_pkg::rpc_result_t res [rpc_pkg::MAX_PUSH]
);
  import rpc_pkg::*;

  logic [CF_W-1:0] current_field;
  logic [15:0]     byte_in_field;
  logic [15:0]     kept_length;
  logic [7:0]      prefix_low;
  logic [15:0]     emitted_count;
  logic            error_seen;

  logic [CF_W-1:0] current_field_next;
  logic [15:0]     byte_in_field_next;
  logic [15:0]     kept_length_next;
  logic [7:0]      prefix_low_next;
  logic [15:0]     emitted_count_next;
  logic            error_seen_next;

  always_comb begin
    logic [15:0] len;
    logic [1:0]  pre;
    logic [15:0] d;
    logic [15:0] pv;
    logic [15:0] cap;
    logic [15:0] kept;
    logic [16:0] i_inc;
    logic [17:0] ec_sum;
    logic [7:0]  vals [MAX_PUSH];
    logic [1:0]  nb;
    logic [1:0]  nr;
    logic        active;
    logic        still;

    len = (entry.field_length == 16'd0) ? 16'd1 : entry.field_length;
    pre = (entry.prefix_size == 2'd3) ? PRE_TWO : entry.prefix_size;
    d   = (len > 16'd2) ? (len - 16'd2) : 16'd0;
    pv  = (pre == PRE_ONE) ? {8'h00, data_byte} : {data_byte, prefix_low};
    cap = len - {14'b0, pre};
    kept = (pv > cap) ? cap : pv;
    i_inc = {1'b0, byte_in_field} + 17'd1;
    active = current_field < count_eff;

    for (int k = 0; k < MAX_PUSH; k++) begin
      vals[k] = 8'h00;
    end
    nb = 2'd0;
    current_field_next = current_field;
    byte_in_field_next = byte_in_field;
    kept_length_next   = kept_length;
    prefix_low_next    = prefix_low;
    error_seen_next    = error_seen;

    if (active) begin
      if (entry.fixed_binary) begin
        if (byte_in_field == 16'd0) begin
          vals[0] = d[7:0];
          vals[1] = d[15:8];
          nb = 2'd2;
        end
        if (byte_in_field < d) begin
          vals[nb] = data_byte;
          nb = nb + 2'd1;
        end
      end else if (pre == PRE_NONE || len < {14'b0, pre}) begin
        if (pre != PRE_NONE && byte_in_field == 16'd0) begin
          error_seen_next = 1'b1;
        end
        vals[0] = data_byte;
        nb = 2'd1;
      end else if (byte_in_field < {14'b0, pre}) begin
        if (pre == PRE_TWO && byte_in_field == 16'd0) begin
          prefix_low_next = data_byte;
        end else begin
          if (pv > cap) begin
            error_seen_next = 1'b1;
          end
          kept_length_next = kept;
          vals[0] = kept[7:0];
          vals[1] = kept[15:8];
          nb = (pre == PRE_TWO) ? 2'd2 : 2'd1;
        end
      end else if ((byte_in_field - {14'b0, pre}) < kept_length) begin
        vals[0] = data_byte;
        nb = 2'd1;
      end

      if (i_inc >= {1'b0, len}) begin
        byte_in_field_next = 16'd0;
        current_field_next = current_field + CF_W'(1);
      end else begin
        byte_in_field_next = i_inc[15:0];
      end
    end

    // saturating byte count
    ec_sum = {2'b00, emitted_count} + {16'b0, nb};
    emitted_count_next = (ec_sum > 18'h0FFFF) ? 16'hFFFF : ec_sum[15:0];
    still = current_field_next < count_eff;

    // an empty closing step still gets one marker result
    nr = (last_byte && nb == 2'd0) ? 2'd1 : nb;

    for (int k = 0; k < MAX_PUSH; k++) begin
      res[k].out_byte      = vals[k];
      res[k].byte_valid    = (2'(k) < nb);
      res[k].record_done   = 1'b0;
      res[k].packed_length = 16'd0;
      res[k].status        = STATUS_OK;
      if (last_byte && (2'(k) == nr - 2'd1)) begin
        res[k].record_done   = 1'b1;
        res[k].packed_length = emitted_count_next;
        res[k].status        = still ? STATUS_EARLY :
                               (error_seen_next ? STATUS_PREFIX : STATUS_OK);
      end
    end
    push_n = nr;

    if (last_byte) begin
      current_field_next = '0;
      byte_in_field_next = 16'd0;
      kept_length_next   = 16'd0;
      prefix_low_next    = 8'h00;
      emitted_count_next = 16'd0;
      error_seen_next    = 1'b0;
    end
  end

  // address for the table prefetch
  assign field_next = rst ? '0 : (byte_accept ? current_field_next : current_field);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_field <= '0;
      byte_in_field <= 16'd0;
      kept_length   <= 16'd0;
      prefix_low    <= 8'h00;
      emitted_count <= 16'd0;
      error_seen    <= 1'b0;
    end else if (byte_accept) begin
      current_field <= current_field_next;
      byte_in_field <= byte_in_field_next;
      kept_length   <= kept_length_next;
      prefix_low    <= prefix_low_next;
      emitted_count <= emitted_count_next;
      error_seen    <= error_seen_next;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (byte_accept && last_byte) |=> (current_field == '0 && emitted_count == 16'd0))
    else $error("record state not cleared after closing item");

  a_field_bounded: assert property (@(posedge clk) disable iff (rst)
    (byte_accept && !last_byte && current_field < count_eff) |=>
      (current_field <= $past(current_field) + CF_W'(1)))
    else $error("field index advanced by more than one");

endmodule

FILE: rtl/core/rpc_queue.sv
// result queue, up to three pushes and one pop per cycle
// depends on rpc_pkg
module rpc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_n,
  input  rpc_pkg::rpc_result_t push_res [rpc_pkg::MAX_PUSH],
  output logic                 space_low,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpc_pkg::rpc_result_t head
);
  import rpc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rpc_result_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = slots[rd_ptr];
  // room must exist for a worst-case item before it is taken
  assign space_low = count > CNT_W'(QUEUE_DEPTH - MAX_PUSH);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (2'(k) < push_n) begin
        slots[wr_ptr + PTR_W'(k)] <= push_res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> (count + CNT_W'(push_n) <= CNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved with no push or pop");

endmodule

FILE: sim/record_pack_compactor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for record_pack_compactor: drives descriptor loads and record bytes,
// predicts every packed byte and record close in its own model and checks the result stream
// depends on rpc_pkg and the record_pack_compactor rtl
module record_pack_compactor_tb;
  import rpc_pkg::*;

  localparam int MAX_FIELDS     = rpc_pkg::MAX_FIELDS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int HOLD_LENGTH    = 80;    // long receiver hold-off in the pressure test
  localparam int RANDOM_ITEMS   = 120;

  // one input item as the sender sees it
  typedef struct packed {
    logic        req_type;
    logic [5:0]  field_slot;
    logic [15:0] field_length;
    logic [1:0]  prefix_size;
    logic        fixed_binary;
    logic [7:0]  data_byte;
    logic        last_byte;
  } pack_req_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [5:0]  field_slot;
  logic [15:0] field_length;
  logic [1:0]  prefix_size;
  logic        fixed_binary;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        record_done;
  logic [15:0] packed_length;
  logic [1:0]  status;

  // packing model state, mirrors the block
  rpc_entry_t  layout [MAX_FIELDS];
  logic [6:0]  field_count_q;
  logic [6:0]  cur_field;
  logic [15:0] pos_in_field;
  logic [15:0] kept_len;
  logic [7:0]  low_byte;
  logic [15:0] out_count;
  logic [1:0]  err_flag;

  // packed results still owed by the block, oldest first
  rpc_result_t pending [$];
  // results produced by the item being predicted
  rpc_result_t step_results [$];

  int  mismatches;
  int  items_sent;
  int  quiet_cycles;
  int  hold_cycles;
  bit  idle_on;
  rpc_result_t got;
  rpc_result_t want;

  record_pack_compactor uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .field_slot   (field_slot),
    .field_length (field_length),
    .prefix_size  (prefix_size),
    .fixed_binary (fixed_binary),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .record_done  (record_done),
    .packed_length(packed_length),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // packing model
  // ---------------------------------------------------------------------------

  // one emitted byte; the packed length saturates at its top value
  function automatic void put_packed_byte(input logic [7:0] b);
    rpc_result_t res;
    res = '0;
    res.out_byte = b;
    res.byte_valid = 1'b1;
    step_results.push_back(res);
    if (out_count != 16'hFFFF) out_count = out_count + 16'd1;
  endfunction

  // length prefix: clamp to the data area and flag it, then emit one or two bytes
  function automatic void keep_prefix(input logic [15:0] value, input logic [15:0] cap,
                                      input logic [1:0] pre);
    logic [15:0] kept;
    kept = value;
    if (kept > cap) begin
      kept = cap;
      err_flag = STATUS_PREFIX;
    end
    kept_len = kept;
    put_packed_byte(kept[7:0]);
    if (pre == PRE_TWO) put_packed_byte(kept[15:8]);
  endfunction

  // works out every result that one accepted item causes and queues them
  task automatic predict_packing(input pack_req_t r);
    rpc_entry_t  ent;
    rpc_result_t closing;
    logic [15:0] len;
    logic [15:0] data_len;
    logic [15:0] pos;
    logic [1:0]  pre;
    logic [6:0]  count;
    begin
      step_results.delete();
      if (r.req_type == REQ_LOAD) begin
        layout[r.field_slot] = {r.fixed_binary, r.prefix_size, r.field_length};
      end else begin
        count = (field_count_q > MAX_FIELDS) ? 7'(MAX_FIELDS) : field_count_q;
        if (cur_field < count) begin
          ent = layout[cur_field[5:0]];
          len = (ent.field_length == 16'd0) ? 16'd1 : ent.field_length;
          pre = (ent.prefix_size == 2'd3) ? PRE_TWO : ent.prefix_size;
          pos = pos_in_field;
          if (ent.fixed_binary) begin
            // synthesized prefix of length minus two, then that many bytes
            data_len = (len > 16'd2) ? len - 16'd2 : 16'd0;
            if (pos == 16'd0) begin
              put_packed_byte(data_len[7:0]);
              put_packed_byte(data_len[15:8]);
            end
            if (pos < data_len) put_packed_byte(r.data_byte);
          end else if (pre == PRE_NONE || len < 16'(pre)) begin
            // plain field, or a field too short to hold its prefix
            if (pre != PRE_NONE && pos == 16'd0) err_flag = STATUS_PREFIX;
            put_packed_byte(r.data_byte);
          end else if (pos < 16'(pre)) begin
            if (pre == PRE_ONE)
              keep_prefix({8'd0, r.data_byte}, len - 16'd1, PRE_ONE);
            else if (pos == 16'd0)
              low_byte = r.data_byte;
            else
              keep_prefix({r.data_byte, low_byte}, len - 16'd2, PRE_TWO);
          end else if (pos - 16'(pre) < kept_len) begin
            put_packed_byte(r.data_byte);
          end
          pos = pos + 16'd1;
          if (pos >= len) begin
            pos_in_field = 16'd0;
            cur_field = cur_field + 7'd1;
          end else begin
            pos_in_field = pos;
          end
        end
        if (r.last_byte) begin
          // the close rides on the last result, or on an empty one
          if (step_results.size() == 0) step_results.push_back('0);
          closing = step_results.pop_back();
          closing.record_done = 1'b1;
          closing.packed_length = out_count;
          closing.status = (cur_field < count) ? STATUS_EARLY : err_flag;
          step_results.push_back(closing);
          cur_field = '0;
          pos_in_field = '0;
          kept_len = '0;
          low_byte = '0;
          out_count = '0;
          err_flag = STATUS_OK;
        end
      end
      foreach (step_results[k]) pending.push_back(step_results[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one item at a falling edge and holds it until accepted
  task automatic send_item(input pack_req_t r);
    begin
      while (idle_on && $urandom_range(99) < 23) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      @(negedge clk);
      req_type     = r.req_type;
      field_slot   = r.field_slot;
      field_length = r.field_length;
      prefix_size  = r.prefix_size;
      fixed_binary = r.fixed_binary;
      data_byte    = r.data_byte;
      last_byte    = r.last_byte;
      in_valid     = 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      predict_packing(r);
      items_sent++;
    end
  endtask

  // descriptor load; the byte fields are don't-care and get random values
  task automatic load_field(input logic [5:0] slot, input logic [15:0] len,
                            input logic [1:0] pre, input logic fix);
    pack_req_t r;
    begin
      r = {REQ_LOAD, slot, len, pre, fix, 8'($urandom), 1'($urandom)};
      send_item(r);
    end
  endtask

  // record byte; the descriptor fields are don't-care and get random values
  task automatic send_byte(input logic [7:0] b, input logic fin);
    pack_req_t r;
    begin
      r = {REQ_BYTE, 6'($urandom), 16'($urandom), 2'($urandom), 1'($urandom), b, fin};
      send_item(r);
    end
  endtask

  // lowers valid and waits until every owed result has come out
  task automatic wait_drained();
    begin
      @(negedge clk);
      in_valid = 1'b0;
      while (pending.size() != 0) @(posedge clk);
      // a trailing load or dropped byte may still be in flight
      repeat (4) @(posedge clk);
    end
  endtask

  // field_count is written only with the block idle
  task automatic write_count(input logic [6:0] v);
    begin
      wait_drained();
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_wdata = v;
      @(negedge clk);
      cfg_we    = 1'b0;
      field_count_q = v;
    end
  endtask

  // mostly short descriptors, some medium, a few of any length
  function automatic rpc_entry_t random_entry();
    rpc_entry_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)      e.field_length = 16'($urandom_range(6));
    else if (pick < 90) e.field_length = 16'($urandom_range(24, 7));
    else                e.field_length = 16'($urandom);
    e.prefix_size  = 2'($urandom_range(3));
    e.fixed_binary = ($urandom_range(3) == 0);
    return e;
  endfunction

  // one record over the current layout; prefix bytes mostly fit their field,
  // the record mostly ends exactly, sometimes early, sometimes with trailing bytes
  task automatic send_record(input bit noise, input bit exact);
    rpc_entry_t  ent;
    logic [15:0] val;
    logic [7:0]  b;
    int count, total, n_bytes, sent, f, i, eff_len, pre, mode;
    begin
      count = (field_count_q > MAX_FIELDS) ? MAX_FIELDS : field_count_q;
      total = 0;
      for (f = 0; f < count; f++)
        total += (layout[f].field_length == 0) ? 1 : layout[f].field_length;
      mode = $urandom_range(99);
      if (exact)                          n_bytes = total;
      else if (total > 60)                n_bytes = $urandom_range(40, 1);
      else if (mode < 70)                 n_bytes = total;
      else if (mode < 85 && total > 1)    n_bytes = $urandom_range(total - 1, 1);
      else                                n_bytes = total + $urandom_range(3, 1);
      if (n_bytes == 0) n_bytes = 1;
      f = 0;
      i = 0;
      val = '0;
      for (sent = 0; sent < n_bytes; sent++) begin
        b = 8'($urandom);
        if (f < count) begin
          ent = layout[f];
          eff_len = (ent.field_length == 0) ? 1 : ent.field_length;
          pre = (ent.prefix_size == 2'd3) ? 2 : ent.prefix_size;
          if (!ent.fixed_binary && pre != 0 && eff_len >= pre && i < pre &&
              $urandom_range(9) < 8) begin
            if (i == 0) val = 16'($urandom_range(eff_len - pre));
            b = (i == 0) ? val[7:0] : val[15:8];
          end
          i++;
          if (i >= eff_len) begin
            i = 0;
            f++;
          end
        end
        // a stray load in the middle of a record
        if (noise && $urandom_range(19) == 0) begin
          ent = random_entry();
          load_field(6'($urandom), ent.field_length, ent.prefix_size, ent.fixed_binary);
        end
        send_byte(b, sent == n_bytes - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, quiet stretches, and a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (!idle_on) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(99) < 23);
      end
    end
  end

  // result checker: each accepted result against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {out_byte, byte_valid, record_done, packed_length, status};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h valid=%b done=%b len=%0d status=%0d",
                   got.out_byte, got.byte_valid, got.record_done, got.packed_length,
                   got.status);
      end else begin
        want = pending.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.record_done !== want.record_done ||
            got.packed_length !== want.packed_length || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected byte=%h valid=%b done=%b len=%0d status=%0d",
                     want.out_byte, want.byte_valid, want.record_done, want.packed_length,
                     want.status);
            $display("          actual   byte=%h valid=%b done=%b len=%0d status=%0d",
                     got.out_byte, got.byte_valid, got.record_done, got.packed_length,
                     got.status);
          end
        end
      end
    end
  end

  // watchdog: too long with nothing moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    begin
      load_field(6'd0, 16'd0, PRE_NONE, 1'b0);  // zero length acts as one
      load_field(6'd1, 16'd3, 2'd3, 1'b0);      // prefix size three acts as two
      load_field(6'd2, 16'd1, PRE_TWO, 1'b0);   // field shorter than its prefix
      load_field(6'd3, 16'd0, PRE_NONE, 1'b1);  // short fixed binary
      load_field(6'd4, 16'd4, PRE_ONE, 1'b0);   // prefix beyond the data area
      load_field(6'd5, 16'd5, PRE_TWO, 1'b1);   // fixed binary overrides the prefix
      write_count(7'd6);
      // full record plus one trailing byte that is dropped
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h00, 1'b0);
      load_field(6'd40, 16'd9, PRE_ONE, 1'b0);  // load must not disturb the record
      send_byte(8'h77, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h5A, 1'b1);
      // ends early while a prefix low byte is pending, close has no byte of its own
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b1);
      // empty layout drops everything
      write_count(7'd0);
      send_byte(8'hC3, 1'b1);
      // widest field with a two-byte prefix that gets clamped, then ended early
      load_field(6'd0, 16'hFFFF, PRE_TWO, 1'b0);
      write_count(7'd1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
    end
  endtask

  // count above the table size acts as the table size; every slot gets loaded here
  task automatic test_full_layout();
    int k;
    begin
      for (k = 0; k < MAX_FIELDS; k++)
        load_field(6'(k), 16'($urandom_range(2)), 2'($urandom_range(3)),
                   $urandom_range(3) == 0);
      write_count(7'd127);
      send_record(1'b0, 1'b1);
    end
  endtask

  // fixed-binary fields burst two results per item while the receiver holds off
  task automatic test_backpressure();
    int k;
    begin
      for (k = 0; k < 16; k++) load_field(6'(k), 16'd1, PRE_NONE, 1'b1);
      write_count(7'd16);
      idle_on = 1'b0;
      hold_cycles = HOLD_LENGTH;
      for (k = 0; k < 16; k++) send_byte(8'($urandom), k == 15);
      // sender waits here for every owed result
      wait_drained();
      idle_on = 1'b1;
    end
  endtask

  task automatic test_random_records();
    rpc_entry_t ent;
    int start, count, k, pick;
    begin
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
        // a stretch in the middle with no idling on either side
        idle_on = !((items_sent - start) >= 40 && (items_sent - start) < 90);
        if ($urandom_range(3) == 0) begin
          pick = $urandom_range(9);
          if (pick == 0)      write_count(7'd0);
          else if (pick == 1) write_count(7'd127);
          else                write_count(7'($urandom_range(6, 1)));
        end
        count = (field_count_q > MAX_FIELDS) ? MAX_FIELDS : field_count_q;
        if (count == 0) count = 1;
        for (k = $urandom_range(3, 1); k > 0; k--) begin
          ent = random_entry();
          load_field(6'($urandom_range(count - 1)), ent.field_length, ent.prefix_size,
                     ent.fixed_binary);
        end
        send_record(1'b1, 1'b0);
      end
      idle_on = 1'b1;
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    req_type      = REQ_LOAD;
    field_slot    = '0;
    field_length  = '0;
    prefix_size   = PRE_NONE;
    fixed_binary  = 1'b0;
    data_byte     = '0;
    last_byte     = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    hold_cycles   = 0;
    idle_on       = 1'b1;
    field_count_q = '0;
    cur_field     = '0;
    pos_in_field  = '0;
    kept_len      = '0;
    low_byte      = '0;
    out_count     = '0;
    err_flag      = STATUS_OK;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_full_layout();
    test_backpressure();
    test_random_records();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rpc_pkg.sv
rtl/core/rpc_table.sv
rtl/core/rpc_step.sv
rtl/core/rpc_queue.sv
rtl/core/record_pack_compactor.sv
sim/record_pack_compactor_tb.sv
